### hw/rtl/ffra_pkg.sv
package ffra_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int ADDR_BITS  = 24;

  localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
  localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int SIZE_W      = ADDR_BITS + 1;
  localparam int FSIZE_W     = 16;

  // The dividend is the last address, start plus size minus one, which can need two bits
  // more than an address.
  localparam int DIV_W       = ADDR_BITS + 2;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam int CFG_DATA_W  = FSIZE_W;
  localparam int IN_BITS     = ADDR_BITS + SIZE_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + 2 + 2 * FRAME_IDX_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [0:0] {
    REG_FRAME_LEN   = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_GRANT = 2'd0,
    STATUS_START = 2'd1,
    STATUS_BUSY  = 2'd2,
    STATUS_ZERO  = 2'd3
  } status_t;

endpackage

### hw/rtl/ffra_div.sv
module ffra_div
  import ffra_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [FSIZE_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FSIZE_W-1:0]   rem;
  logic [DIV_W-1:0]     quo;
  logic [FSIZE_W:0]     rem_sh;
  logic [FSIZE_W:0]     diff;
  logic                 fits;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    diff   = rem_sh - {1'b0, divisor};
    fits   = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[FSIZE_W-1:0] : rem_sh[FSIZE_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/ffra_bitmap.sv
module ffra_bitmap #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fixed_frame_range_allocator.sv
// Channel  Dir  Width  Contents (lowest bit first)
// s_*      in   56     base_addr[23:0], req_size[48:24]
// m_*      out  24     granted[0], status[2:1], first_frame[10:3], last_frame[18:11]
// cfg_*    in   1+16   register index, write data; no read-back
//
// From one acceptance to the earliest next, a granted request makes two passes through the
// shared divider, takes an address step and a check step per frame to check the bitmap, a step
// per frame to mark it, and one step to load the result. Rejected requests stop early.
// After reset s_tready stays low while the bitmap is cleared;
// frame_len is 1 and frame_count 256.
// A finished result waits in the output register; the next request is taken meanwhile.
module fixed_frame_range_allocator
  import ffra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // base_addr, req_size
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // granted, status, first_frame, last_frame
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DIV_FIRST = 7'b0000010,
    S_DIV_LAST  = 7'b0000100,
    S_SCAN      = 7'b0001000,
    S_MARK      = 7'b0010000,
    S_DONE      = 7'b0100000,
    S_SPARE     = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [FSIZE_W-1:0]     frame_len;
  logic [COUNT_W-1:0]     frame_count;
  logic [FSIZE_W-1:0]     divisor;
  logic [COUNT_W-1:0]     count_eff;

  logic [ADDR_BITS-1:0]   in_addr;
  logic [SIZE_W-1:0]      in_size;
  logic [DIV_W-1:0]       last_addr;
  logic [DIV_W-1:0]       div_dividend;
  logic [DIV_W-1:0]       quotient;
  logic                   div_start;
  logic                   div_done;
  logic                   q_in_range;

  logic [FRAME_IDX_W-1:0] idx;
  logic [FRAME_IDX_W-1:0] first_frame;
  logic [FRAME_IDX_W-1:0] last_frame;
  logic                   scan_chk;
  logic                   used;
  logic                   mark;
  status_t                status;
  logic                   accept;
  logic                   out_load;

  logic                   clearing;
  logic [FRAME_IDX_W-1:0] clr_idx;
  logic                   bm_we;
  logic [FRAME_IDX_W-1:0] bm_waddr;
  logic [0:0]             bm_wdata;
  logic [0:0]             bm_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len   <= FSIZE_W'(1);
      frame_count <= COUNT_W'(MAX_FRAMES);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FRAME_LEN:   frame_len   <= cfg_data;
        REG_FRAME_COUNT: frame_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign divisor   = (frame_len == '0) ? FSIZE_W'(1) : frame_len;
  assign count_eff = (frame_count > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                           : frame_count;

  assign in_addr  = s_tdata[ADDR_BITS-1:0];
  assign in_size  = s_tdata[IN_BITS-1:ADDR_BITS];
  assign s_tready = (state == S_IDLE) && !clearing;
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign q_in_range = (quotient < DIV_W'(count_eff));

  assign div_dividend = (state == S_IDLE) ? DIV_W'(in_addr) : last_addr;
  assign div_start    = (accept && in_size != '0) ||
                        (state == S_DIV_FIRST && div_done && q_in_range);

  ffra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // After reset every frame is written free, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == FRAME_IDX_W'(MAX_FRAMES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mark     = (state == S_MARK);
  assign bm_we    = clearing || mark;
  assign bm_waddr = clearing ? clr_idx : idx;
  assign bm_wdata = ~clearing;
  assign used     = bm_rdata[0];

  ffra_bitmap #(
    .WIDTH (1),
    .DEPTH (MAX_FRAMES)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (idx),
    .rdata (bm_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_size == '0) ? S_DONE : S_DIV_FIRST;
        end
      end
      S_DIV_FIRST: begin
        if (div_done) begin
          state_next = q_in_range ? S_DIV_LAST : S_DONE;
        end
      end
      S_DIV_LAST: begin
        if (div_done) begin
          state_next = q_in_range ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_chk) begin
          if (used) begin
            state_next = S_DONE;
          end else if (idx == last_frame) begin
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (idx == last_frame) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The bitmap read is registered, so each frame takes an address step and then a check step.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          last_addr <= DIV_W'(in_addr) + DIV_W'(in_size) - DIV_W'(1);
          status    <= (in_size == '0) ? STATUS_ZERO : STATUS_GRANT;
        end
      end
      S_DIV_FIRST: begin
        if (div_done) begin
          first_frame <= quotient[FRAME_IDX_W-1:0];
          idx         <= quotient[FRAME_IDX_W-1:0];
          if (!q_in_range) begin
            status <= STATUS_START;
          end
        end
      end
      S_DIV_LAST: begin
        if (div_done) begin
          last_frame <= quotient[FRAME_IDX_W-1:0];
          scan_chk   <= 1'b0;
          if (!q_in_range) begin
            status <= STATUS_BUSY;
          end
        end
      end
      S_SCAN: begin
        if (!scan_chk) begin
          scan_chk <= 1'b1;
        end else if (used) begin
          status <= STATUS_BUSY;
        end else if (idx == last_frame) begin
          idx <= first_frame;
        end else begin
          idx      <= idx + 1'b1;
          scan_chk <= 1'b0;
        end
      end
      S_MARK: begin
        if (idx != last_frame) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register; a result may sit here while the next request is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (status == STATUS_GRANT) begin
        m_tdata <= OUT_DATA_W'({last_frame, first_frame, status, 1'b1});
      end else begin
        m_tdata <= OUT_DATA_W'({{(2 * FRAME_IDX_W){1'b0}}, status, 1'b0});
      end
    end
  end

endmodule
